>>> src/ise_pkg.sv
package ise_pkg;

  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  typedef struct packed {
    logic insert;
    logic mark_ovf;
    logic pop;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic one;
    logic out_valid;
  } status_t;

endpackage

>>> src/insertion_sort_engine.sv
// Streaming insertion sort of signed 32-bit values.
// Input channel: value, last with value_valid / value_stall. An item is
// taken on a rising edge with valid high and stall low.
// Output channel: sorted_value, last_out, overflow with sorted_valid /
// sorted_stall, one result per handshake.
// Each value is inserted by a row of MAX_ITEMS compare-and-shift cells,
// so input items are taken one per cycle while the input is not stalled.
// After the item flagged last, the input stalls while the run is shifted
// out of cell 0, one result per cycle when the receiver does not stall;
// the first result is registered after the controller enters its emit state.
// A run of N held values yields N results.
// The output register frees the input as soon as the final result is
// loaded, so the next run may start while that result waits.
// Values beyond MAX_ITEMS are dropped and overflow is set on that run's
// results. A stalled result holds until taken.
// Reset (rst, synchronous) empties the list and clears the output valid.
module insertion_sort_engine #(
  parameter int MAX_ITEMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] value,
  input  logic               last,
  input  logic               value_valid,
  output logic               value_stall,
  output logic signed [31:0] sorted_value,
  output logic               last_out,
  output logic               overflow,
  output logic               sorted_valid,
  input  logic               sorted_stall
);

  ise_pkg::cmd_t    cmd;
  ise_pkg::status_t status;

  ise_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .value_valid  (value_valid),
    .last         (last),
    .sorted_stall (sorted_stall),
    .status       (status),
    .cmd          (cmd),
    .value_stall  (value_stall)
  );

  ise_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .sorted_stall (sorted_stall),
    .status       (status),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow),
    .sorted_valid (sorted_valid)
  );

endmodule

>>> src/ise_ctrl.sv
module ise_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             value_valid,
  input  logic             last,
  input  logic             sorted_stall,
  input  ise_pkg::status_t status,
  output ise_pkg::cmd_t    cmd,
  output logic             value_stall
);

  ise_pkg::state_t state;
  ise_pkg::state_t state_next;
  logic            accept;

  assign value_stall = (state != ise_pkg::ST_FILL);
  assign accept      = value_valid && !value_stall;

  always_comb begin
    cmd.insert   = accept && !status.full;
    cmd.mark_ovf = accept && status.full;
    cmd.pop      = (state == ise_pkg::ST_EMIT) && (!status.out_valid || !sorted_stall);
  end

  always_comb begin
    state_next = state;
    case (state)
      ise_pkg::ST_FILL: begin
        if (accept && last) state_next = ise_pkg::ST_EMIT;
      end
      ise_pkg::ST_EMIT: begin
        if (cmd.pop && status.one) state_next = ise_pkg::ST_FILL;
      end
      default: state_next = ise_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ise_pkg::ST_FILL;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/ise_datapath.sv
module ise_datapath #(
  parameter int MAX_ITEMS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ise_pkg::cmd_t      cmd,
  input  logic signed [31:0] value,
  input  logic               sorted_stall,
  output ise_pkg::status_t   status,
  output logic signed [31:0] sorted_value,
  output logic               last_out,
  output logic               overflow,
  output logic               sorted_valid
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic signed [31:0] cells [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] lt;
  logic [CW-1:0]        count;
  logic                 ovf;

  assign status.full      = (count == CW'(MAX_ITEMS));
  assign status.one       = (count == CW'(1));
  assign status.out_valid = sorted_valid;

  // row of compare-and-shift cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic write_en;
    logic signed [31:0] cell_in;

    assign lt[i]    = value < cells[i];
    assign write_en = cmd.insert && (CW'(i) <= count) && ((CW'(i) == count) || lt[i]);

    if (i == 0) begin : g_first
      assign cell_in = value;
    end else begin : g_rest
      assign cell_in = lt[i-1] ? cells[i-1] : value;
    end

    always_ff @(posedge clk) begin
      if (write_en) begin
        cells[i] <= cell_in;
      end else if (cmd.pop) begin
        if (i < MAX_ITEMS - 1) cells[i] <= cells[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      sorted_valid <= 1'b0;
    end else begin
      if (cmd.insert) count <= count + CW'(1);
      if (cmd.mark_ovf) ovf <= 1'b1;
      if (cmd.pop) begin
        count        <= count - CW'(1);
        sorted_valid <= 1'b1;
        if (status.one) ovf <= 1'b0;
      end else if (!sorted_stall) begin
        sorted_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      sorted_value <= cells[0];
      last_out     <= status.one;
      overflow     <= ovf;
    end
  end

endmodule

>>> src/ise_checker.sv
module ise_checker (
  input logic               clk,
  input logic               rst,
  input logic               value_valid,
  input logic               value_stall,
  input logic               last,
  input logic signed [31:0] sorted_value,
  input logic               last_out,
  input logic               overflow,
  input logic               sorted_valid,
  input logic               sorted_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    sorted_valid && sorted_stall |=> sorted_valid && $stable(sorted_value)
      && $stable(last_out) && $stable(overflow))
    else $error("stalled result changed");

  a_stall_after_last: assert property (@(posedge clk) disable iff (rst)
    value_valid && !value_stall && last |=> value_stall)
    else $error("input taken while run is emitted");

  a_emit_load: assert property (@(posedge clk) disable iff (rst)
    value_stall && !sorted_valid |=> sorted_valid)
    else $error("run not emitted while output empty");

  a_ascending: assert property (@(posedge clk) disable iff (rst)
    sorted_valid && !sorted_stall && !last_out |=> sorted_valid
      && (sorted_value >= $past(sorted_value)) && (overflow == $past(overflow)))
    else $error("results out of order or overflow changed in run");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (
  .clk          (clk),
  .rst          (rst),
  .value_valid  (value_valid),
  .value_stall  (value_stall),
  .last         (last),
  .sorted_value (sorted_value),
  .last_out     (last_out),
  .overflow     (overflow),
  .sorted_valid (sorted_valid),
  .sorted_stall (sorted_stall)
);

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CAP         = 16;
  localparam int IDLE_PCT    = 32;
  localparam int QUIET_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 150;

  typedef struct {
    logic signed [31:0] val;
    logic               fin;
    logic               ovf;
  } sorted_res_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic signed [31:0] value        = '0;
  logic               last         = 1'b0;
  logic               value_valid  = 1'b0;
  logic               value_stall;
  logic signed [31:0] sorted_value;
  logic               last_out;
  logic               overflow;
  logic               sorted_valid;
  logic               sorted_stall = 1'b0;

  logic signed [31:0] held_vals [CAP];
  int                 held_n       = 0;
  logic               dropped      = 1'b0;
  sorted_res_t        sorted_q [$];

  bit send_idle    = 1'b1;
  bit recv_idle    = 1'b1;
  int err_count    = 0;
  int quiet_cycles = 0;
  int sent_items   = 0;

  insertion_sort_engine #(
    .MAX_ITEMS(CAP)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .last        (last),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .sorted_value(sorted_value),
    .last_out    (last_out),
    .overflow    (overflow),
    .sorted_valid(sorted_valid),
    .sorted_stall(sorted_stall)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (err_count < 100) $display("ERROR %0t: %s", $time, msg);
    err_count++;
  endtask

  // insert into the held list; a last item releases the whole run
  task automatic take_value(input logic signed [31:0] v, input logic l);
    int pos;
    sorted_res_t res;
    if (held_n < CAP) begin
      pos = held_n;
      while (pos > 0 && v < held_vals[pos-1]) begin
        held_vals[pos] = held_vals[pos-1];
        pos--;
      end
      held_vals[pos] = v;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (l) begin
      for (int k = 0; k < held_n; k++) begin
        res.val = held_vals[k];
        res.fin = (k == held_n - 1);
        res.ovf = dropped;
        sorted_q.push_back(res);
      end
      held_n  = 0;
      dropped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    sorted_res_t exp_res;
    if (!rst && sorted_valid && !sorted_stall) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d", sorted_value));
      end else begin
        exp_res = sorted_q.pop_front();
        if (sorted_value !== exp_res.val)
          report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                    sorted_value, exp_res.val));
        if (last_out !== exp_res.fin)
          report_mismatch($sformatf("last_out %b, expected %b", last_out, exp_res.fin));
        if (overflow !== exp_res.ovf)
          report_mismatch($sformatf("overflow %b, expected %b", overflow, exp_res.ovf));
      end
    end
    sorted_stall <= recv_idle && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst || (value_valid && !value_stall) || (sorted_valid && !sorted_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic signed [31:0] v, input logic l);
    while (send_idle && $urandom_range(99) < IDLE_PCT) begin
      value_valid <= 1'b0;
      @(posedge clk);
    end
    value       <= v;
    last        <= l;
    value_valid <= 1'b1;
    do @(posedge clk); while (value_stall);
    take_value(v, l);
    sent_items++;
  endtask

  task automatic wait_drained();
    value_valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_value();
    int s;
    case ($urandom_range(9))
      5, 6: begin
        s = $urandom_range(8);
        return s - 4;
      end
      7: return 32'h7fff_ffff;
      8: return 32'h8000_0000;
      9: return $urandom_range(1) ? 32'sd0 : -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(8, 1);
    if (r < 80) return $urandom_range(15, 9);
    if (r < 90) return CAP;
    return $urandom_range(CAP + 4, CAP + 1);
  endfunction

  task automatic send_run(input int n);
    for (int i = 0; i < n; i++) send_item(rand_value(), i == n - 1);
  endtask

  task automatic test_directed();
    send_item(32'h7fff_ffff, 1'b1);
    send_item(32'sd0, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'sd1, 1'b1);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd3, 1'b0);
    send_item(32'sd5, 1'b1);
    wait_drained();
  endtask

  // full store exactly, then a run whose tail (last item too) is dropped
  task automatic test_overflow();
    for (int i = 0; i < CAP; i++) send_item(i * 7 - 50, i == CAP - 1);
    for (int i = 0; i < CAP + 2; i++) send_item(100 - i, i == CAP + 1);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_run(CAP);
    send_run(1);
    send_run(1);
    send_run(CAP + 2);
    send_run(3);
    send_run(1);
    for (int i = 0; i < 4; i++) send_run(pick_len());
    send_idle = 1'b1;
    recv_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_random();
    int start;
    int runs;
    start = sent_items;
    runs  = 0;
    while (sent_items - start < RANDOM_ITEMS) begin
      send_run(pick_len());
      runs++;
      if (runs % 7 == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_back_to_back();
    test_random();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

>>> filelist.f
src/ise_pkg.sv
src/ise_ctrl.sv
src/ise_datapath.sv
src/insertion_sort_engine.sv
src/ise_checker.sv
sim/tb.sv
